// ----- rtl/core/m3inv_pkg.sv -----
// Shared constants and control types for the 3x3 matrix inverse pipeline.
package m3inv_pkg;

    localparam int LANES    = 9;
    localparam int OUT_W    = 32;
    localparam int OUT_FRAC = 16;
    localparam int INT_BITS = 4;
    localparam int Q_STEPS  = 32;

    typedef struct packed {
        logic             valid;
        logic             singular;
        logic [LANES-1:0] neg;
        logic [LANES-1:0] ovf;
    } ctrl_t;

endpackage

// ----- rtl/core/matrix3x3_inverse.sv -----
// Top level of the pipelined 3x3 matrix inverse by the adjugate.
//
//  Channel   Ports          Direction  Contents
//  input     s_valid/ready  in         columns x, y, z, signed Q4.(IN_WIDTH-4)
//  result    m_valid/ready  out        nine entries of the inverse, Q16.16, and singular
//
// One transaction enters per cycle unless the result side stalls; results leave
// in order after six front stages (products, cross products, determinant partial
// products, the determinant, magnitudes, divider setup), 32 restoring division
// steps, one per stage, and the saturating output register. The divider chain
// sets the depth. Reset (synchronous, active low) clears only the valid bits
// along the pipe. The whole pipe advances whenever the output register is empty
// or being taken, so a stall on the result side freezes every stage and loses nothing.
module matrix3x3_inverse #(
    parameter int IN_WIDTH = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [IN_WIDTH-1:0] s_col_x_0,
    input  logic signed [IN_WIDTH-1:0] s_col_x_1,
    input  logic signed [IN_WIDTH-1:0] s_col_x_2,
    input  logic signed [IN_WIDTH-1:0] s_col_y_0,
    input  logic signed [IN_WIDTH-1:0] s_col_y_1,
    input  logic signed [IN_WIDTH-1:0] s_col_y_2,
    input  logic signed [IN_WIDTH-1:0] s_col_z_0,
    input  logic signed [IN_WIDTH-1:0] s_col_z_1,
    input  logic signed [IN_WIDTH-1:0] s_col_z_2,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [31:0]         m_row0_0,
    output logic signed [31:0]         m_row0_1,
    output logic signed [31:0]         m_row0_2,
    output logic signed [31:0]         m_row1_0,
    output logic signed [31:0]         m_row1_1,
    output logic signed [31:0]         m_row1_2,
    output logic signed [31:0]         m_row2_0,
    output logic signed [31:0]         m_row2_1,
    output logic signed [31:0]         m_row2_2,
    output logic                       m_singular
);
    import m3inv_pkg::*;

    // Divisor width: one bit more than the determinant magnitude, to hold twice it.
    localparam int DW = 3 * IN_WIDTH + 3;

    logic en;

    logic signed [IN_WIDTH-1:0] x [3];
    logic signed [IN_WIDTH-1:0] y [3];
    logic signed [IN_WIDTH-1:0] z [3];

    ctrl_t              ctrl_s [Q_STEPS+1];
    logic [DW-1:0]      d_s    [Q_STEPS+1];
    logic [DW-1:0]      rem_s  [Q_STEPS+1][LANES];
    logic [Q_STEPS-1:0] nq_s   [Q_STEPS+1][LANES];

    logic               out_valid_reg;
    logic               out_sing_reg;
    logic [OUT_W-1:0]   out_row_reg [LANES];
    logic [OUT_W-1:0]   mag [LANES];
    logic [OUT_W-1:0]   res [LANES];

    // Every stage moves together; the output register is the only place that waits.
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    assign x[0] = s_col_x_0;
    assign x[1] = s_col_x_1;
    assign x[2] = s_col_x_2;
    assign y[0] = s_col_y_0;
    assign y[1] = s_col_y_1;
    assign y[2] = s_col_y_2;
    assign z[0] = s_col_z_0;
    assign z[1] = s_col_z_1;
    assign z[2] = s_col_z_2;

    m3inv_front #(
        .W(IN_WIDTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_valid(s_valid),
        .x       (x),
        .y       (y),
        .z       (z),
        .ctrl_out(ctrl_s[0]),
        .d_out   (d_s[0]),
        .rem_out (rem_s[0]),
        .nq_out  (nq_s[0])
    );

    // One quotient bit per stage, most significant first.
    for (genvar g = 0; g < Q_STEPS; g++) begin : g_div
        m3inv_div_step #(
            .DW(DW)
        ) u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ctrl_in (ctrl_s[g]),
            .d_in    (d_s[g]),
            .rem_in  (rem_s[g]),
            .nq_in   (nq_s[g]),
            .ctrl_out(ctrl_s[g+1]),
            .d_out   (d_s[g+1]),
            .rem_out (rem_s[g+1]),
            .nq_out  (nq_s[g+1])
        );
    end

    // Saturation: the positive limit is 2^31-1, the negative one 2^31. A quotient
    // that needed more than 32 bits was flagged in the front and takes the limit.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            logic [OUT_W-1:0] lim;
            lim = ctrl_s[Q_STEPS].neg[i] ? {1'b1, {(OUT_W-1){1'b0}}}
                                         : {1'b0, {(OUT_W-1){1'b1}}};
            if (ctrl_s[Q_STEPS].ovf[i] || (nq_s[Q_STEPS][i] > lim)) begin
                mag[i] = lim;
            end else begin
                mag[i] = nq_s[Q_STEPS][i];
            end
            if (ctrl_s[Q_STEPS].singular) begin
                res[i] = '0;
            end else if (ctrl_s[Q_STEPS].neg[i]) begin
                res[i] = -mag[i];
            end else begin
                res[i] = mag[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= ctrl_s[Q_STEPS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_sing_reg <= ctrl_s[Q_STEPS].singular;
            out_row_reg  <= res;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_singular = out_sing_reg;
    assign m_row0_0   = out_row_reg[0];
    assign m_row0_1   = out_row_reg[1];
    assign m_row0_2   = out_row_reg[2];
    assign m_row1_0   = out_row_reg[3];
    assign m_row1_1   = out_row_reg[4];
    assign m_row1_2   = out_row_reg[5];
    assign m_row2_0   = out_row_reg[6];
    assign m_row2_1   = out_row_reg[7];
    assign m_row2_2   = out_row_reg[8];

endmodule

// ----- rtl/core/m3inv_front.sv -----
// Front stages: cross products, determinant, magnitudes and divider setup.
module m3inv_front #(
    parameter int W = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [W-1:0]         x [3],
    input  logic signed [W-1:0]         y [3],
    input  logic signed [W-1:0]         z [3],
    output m3inv_pkg::ctrl_t            ctrl_out,
    output logic [3*W+2:0]              d_out,
    output logic [3*W+2:0]              rem_out [m3inv_pkg::LANES],
    output logic [m3inv_pkg::Q_STEPS-1:0] nq_out [m3inv_pkg::LANES]
);
    import m3inv_pkg::*;

    localparam int PW = 2 * W;
    localparam int AW = 2 * W + 1;
    localparam int RW = 3 * W + 2;
    localparam int DW = RW + 1;
    localparam int SH = W - INT_BITS + OUT_FRAC + 1;
    localparam int NW = AW + SH + 1;

    logic [5:0] v_reg;

    logic signed [PW-1:0] pa_reg [LANES];
    logic signed [PW-1:0] pb_reg [LANES];
    logic signed [W-1:0]  x1_reg [3];
    logic signed [AW-1:0] adj2_reg [LANES];
    logic signed [W-1:0]  x2_reg [3];
    logic signed [AW-1:0] adj3_reg [LANES];
    logic signed [PW-1:0] ph_reg [3];
    logic signed [PW+1:0] pl_reg [3];
    logic signed [AW-1:0] adj4_reg [LANES];
    logic signed [RW-1:0] r_reg;
    logic [RW-1:0]        rmag_reg;
    logic                 zero_reg;
    logic [LANES-1:0]     neg5_reg;
    logic [AW-1:0]        cmag_reg [LANES];
    logic [DW-1:0]        d_reg;
    logic [DW-1:0]        rem_reg [LANES];
    logic [Q_STEPS-1:0]   nq_reg [LANES];
    logic [LANES-1:0]     ovf_reg;
    logic [LANES-1:0]     neg6_reg;
    logic                 sing6_reg;

    logic signed [W-1:0] a_s [LANES];
    logic signed [W-1:0] b_s [LANES];
    logic signed [W-1:0] c_s [LANES];
    logic signed [W-1:0] e_s [LANES];
    logic signed [RW-1:0] r_next;
    logic [NW-1:0]        num [LANES];

    // Operand routing: adj[3p+k] = a*b - c*e for the pairs (y,z), (z,x), (x,y).
    always_comb begin
        a_s[0] = y[1]; b_s[0] = z[2]; c_s[0] = y[2]; e_s[0] = z[1];
        a_s[1] = y[2]; b_s[1] = z[0]; c_s[1] = y[0]; e_s[1] = z[2];
        a_s[2] = y[0]; b_s[2] = z[1]; c_s[2] = y[1]; e_s[2] = z[0];
        a_s[3] = z[1]; b_s[3] = x[2]; c_s[3] = z[2]; e_s[3] = x[1];
        a_s[4] = z[2]; b_s[4] = x[0]; c_s[4] = z[0]; e_s[4] = x[2];
        a_s[5] = z[0]; b_s[5] = x[1]; c_s[5] = z[1]; e_s[5] = x[0];
        a_s[6] = x[1]; b_s[6] = y[2]; c_s[6] = x[2]; e_s[6] = y[1];
        a_s[7] = x[2]; b_s[7] = y[0]; c_s[7] = x[0]; e_s[7] = y[2];
        a_s[8] = x[0]; b_s[8] = y[1]; c_s[8] = x[1]; e_s[8] = y[0];
    end

    always_comb begin
        r_next = '0;
        for (int k = 0; k < 3; k++) begin
            r_next = r_next + (RW'(ph_reg[k]) <<< (W + 1)) + RW'(pl_reg[k]);
        end
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            num[i] = (NW'(cmag_reg[i]) << SH) + NW'(rmag_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < LANES; i++) begin
                pa_reg[i]   <= a_s[i] * b_s[i];
                pb_reg[i]   <= c_s[i] * e_s[i];
                adj2_reg[i] <= AW'(pa_reg[i]) - AW'(pb_reg[i]);
                adj3_reg[i] <= adj2_reg[i];
                adj4_reg[i] <= adj3_reg[i];
                cmag_reg[i] <= adj4_reg[i][AW-1] ? AW'(-adj4_reg[i]) : AW'(adj4_reg[i]);
                neg5_reg[i] <= adj4_reg[i][AW-1] ^ r_reg[RW-1];
                rem_reg[i]  <= DW'(num[i] >> Q_STEPS);
                nq_reg[i]   <= num[i][Q_STEPS-1:0];
                ovf_reg[i]  <= (num[i] >> Q_STEPS) >= NW'({rmag_reg, 1'b0});
            end
            for (int k = 0; k < 3; k++) begin
                x1_reg[k] <= x[k];
                x2_reg[k] <= x1_reg[k];
                ph_reg[k] <= x2_reg[k] * $signed(adj2_reg[k][AW-1:W+1]);
                pl_reg[k] <= x2_reg[k] * $signed({1'b0, adj2_reg[k][W:0]});
            end
            r_reg     <= r_next;
            rmag_reg  <= r_reg[RW-1] ? RW'(-r_reg) : RW'(r_reg);
            zero_reg  <= (r_reg == '0);
            d_reg     <= {rmag_reg, 1'b0};
            neg6_reg  <= neg5_reg;
            sing6_reg <= zero_reg;
        end
    end

    assign ctrl_out.valid    = v_reg[5];
    assign ctrl_out.singular = sing6_reg;
    assign ctrl_out.neg      = neg6_reg;
    assign ctrl_out.ovf      = ovf_reg;
    assign d_out             = d_reg;
    assign rem_out           = rem_reg;
    assign nq_out            = nq_reg;

endmodule

// ----- rtl/core/m3inv_div_step.sv -----
// One restoring division step for all nine lanes, registered.
module m3inv_div_step #(
    parameter int DW = 51
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  m3inv_pkg::ctrl_t              ctrl_in,
    input  logic [DW-1:0]                 d_in,
    input  logic [DW-1:0]                 rem_in [m3inv_pkg::LANES],
    input  logic [m3inv_pkg::Q_STEPS-1:0] nq_in [m3inv_pkg::LANES],
    output m3inv_pkg::ctrl_t              ctrl_out,
    output logic [DW-1:0]                 d_out,
    output logic [DW-1:0]                 rem_out [m3inv_pkg::LANES],
    output logic [m3inv_pkg::Q_STEPS-1:0] nq_out [m3inv_pkg::LANES]
);
    import m3inv_pkg::*;

    ctrl_t              ctrl_reg;
    logic [DW-1:0]      d_reg;
    logic [DW-1:0]      rem_reg [LANES];
    logic [Q_STEPS-1:0] nq_reg [LANES];
    logic [DW:0]        t [LANES];
    logic [DW:0]        diff [LANES];
    logic [LANES-1:0]   ge;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            t[i]    = {rem_in[i], nq_in[i][Q_STEPS-1]};
            ge[i]   = t[i] >= {1'b0, d_in};
            diff[i] = t[i] - {1'b0, d_in};
        end
    end

    // Only the valid bit is reset; the payload simply follows it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.valid <= 1'b0;
        end else if (en) begin
            ctrl_reg.valid <= ctrl_in.valid;
        end
        if (en) begin
            ctrl_reg.singular <= ctrl_in.singular;
            ctrl_reg.neg      <= ctrl_in.neg;
            ctrl_reg.ovf      <= ctrl_in.ovf;
            d_reg             <= d_in;
            for (int i = 0; i < LANES; i++) begin
                rem_reg[i] <= ge[i] ? diff[i][DW-1:0] : t[i][DW-1:0];
                nq_reg[i]  <= {nq_in[i][Q_STEPS-2:0], ge[i]};
            end
        end
    end

    assign ctrl_out = ctrl_reg;
    assign d_out    = d_reg;
    assign rem_out  = rem_reg;
    assign nq_out   = nq_reg;

endmodule
